// ===== rtl/four_axis_stepper_sync_mover_macros.svh =====
// Assertion macros for the four-axis stepper mover.
// Included by the top level; no other dependencies.
`ifndef FOUR_AXIS_STEPPER_SYNC_MOVER_MACROS_SVH
`define FOUR_AXIS_STEPPER_SYNC_MOVER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define STP4_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stp4 check failed");

// Next-cycle implication, disabled during reset
`define STP4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stp4 check failed");

`endif

// ===== rtl/stp4_pkg.sv =====
// Shared constants, codes and types of the four-axis stepper mover.
// No dependencies.
package stp4_pkg;

    // Channel count and fixed field widths
    localparam int NUM_CH          = 4;
    localparam int CH_BITS         = 2;
    localparam int BASE_BITS       = 10;
    localparam int MASK_BITS       = 4;
    localparam int CFG_IDX_BITS    = 1;
    localparam int POS_BITS_DEF    = 14;
    localparam int PERIOD_BITS_DEF = 16;

    // Register reset values
    localparam logic [BASE_BITS-1:0] BASE_RESET = 10'd150;
    localparam logic [MASK_BITS-1:0] MASK_RESET = 4'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_PERIOD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_MASK    = 1'b1;

    // Input operation codes
    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Step sign codes
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_REPORT,
        ST_TICK
    } t_state;

endpackage

// ===== rtl/stp4_in_if.sv =====
// Input channel of the stepper mover: valid/ready plus the command beat.
// Depends on stp4_pkg for the default position width and the channel index width.
interface stp4_in_if #(
    parameter int POS_BITS = stp4_pkg::POS_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [POS_BITS-1:0]        target_zero;
    logic signed [POS_BITS-1:0]        target_one;
    logic signed [POS_BITS-1:0]        target_two;
    logic signed [POS_BITS-1:0]        target_three;
    logic [stp4_pkg::CH_BITS-1:0]      tick_channel;

    modport source (
        output valid, operation, target_zero, target_one, target_two, target_three,
               tick_channel,
        input  ready
    );
    modport sink (
        input  valid, operation, target_zero, target_one, target_two, target_three,
               tick_channel,
        output ready
    );
endinterface

// ===== rtl/stp4_out_if.sv =====
// Result channel of the stepper mover: valid/ready plus one channel report.
// Depends on stp4_pkg for default widths.
interface stp4_out_if #(
    parameter int POS_BITS    = stp4_pkg::POS_BITS_DEF,
    parameter int PERIOD_BITS = stp4_pkg::PERIOD_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [stp4_pkg::CH_BITS-1:0]      channel;
    logic signed [POS_BITS-1:0]        position;
    logic [PERIOD_BITS-1:0]            step_period;
    logic                              dir_pin;
    logic                              moving;
    logic                              last;

    modport source (
        output valid, channel, position, step_period, dir_pin, moving, last,
        input  ready
    );
    modport sink (
        input  valid, channel, position, step_period, dir_pin, moving, last,
        output ready
    );
endinterface

// ===== rtl/stp4_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by the stepper mover top level.
module stp4_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    // dividend bits shift out at the top while quotient bits shift in below
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_sub;
    logic             w_fit;
    logic [DEN_W-1:0] n_rem;

    // One trial subtraction per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_sub   = w_trial - {1'b0, r_den};
        w_fit   = (w_trial >= {1'b0, r_den});
        n_rem   = w_fit ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    // Control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: remainder and shared dividend/quotient shifter
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/four_axis_stepper_sync_mover.sv =====
// Four-axis stepper mover with synchronized arrival; uses stp4_pkg, stp4_div, the interfaces.
// Tick beat: ST_TICK loads the output register once the slot is free, then goes to ST_IDLE.
// Target beat: ST_DIST finds each channel's distance, ST_MUL scales the largest by the base
// period, then per channel a serial divide of this BASE_BITS+POS_BITS bit (24 at defaults)
// product by its distance, skipped at its aim, and a report; output stalls hold the report.
// Synchronous active-low reset clears all channel state and loads register defaults.
`include "four_axis_stepper_sync_mover_macros.svh"

module four_axis_stepper_sync_mover #(
    parameter int POS_BITS    = stp4_pkg::POS_BITS_DEF,
    parameter int PERIOD_BITS = stp4_pkg::PERIOD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    stp4_in_if.sink                             i_in,
    stp4_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [stp4_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [stp4_pkg::BASE_BITS-1:0]      i_cfg_data
);
    localparam int NUM_BITS  = stp4_pkg::BASE_BITS + POS_BITS;
    localparam int DIFF_BITS = POS_BITS + 1;
    localparam int QW        = (NUM_BITS > PERIOD_BITS) ? NUM_BITS : PERIOD_BITS;
    localparam logic [stp4_pkg::CH_BITS-1:0] LAST_CH = stp4_pkg::CH_BITS'(stp4_pkg::NUM_CH - 1);
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};

    stp4_pkg::t_state r_state, n_state;

    // Configuration
    logic [stp4_pkg::BASE_BITS-1:0] r_base;
    logic [stp4_pkg::MASK_BITS-1:0] r_mask;

    // Per-channel state
    logic [POS_BITS-1:0]         r_pos    [stp4_pkg::NUM_CH];
    logic [POS_BITS-1:0]         r_aim    [stp4_pkg::NUM_CH];
    logic [1:0]                  r_sign   [stp4_pkg::NUM_CH];
    logic [stp4_pkg::NUM_CH-1:0] r_act;
    logic [PERIOD_BITS-1:0]      r_period [stp4_pkg::NUM_CH];

    // Working registers of one item
    logic [POS_BITS-1:0]          r_tgt  [stp4_pkg::NUM_CH];
    logic [POS_BITS-1:0]          r_dist [stp4_pkg::NUM_CH];
    logic [POS_BITS-1:0]          r_maxd;
    logic [NUM_BITS-1:0]          r_num;
    logic [stp4_pkg::CH_BITS-1:0] r_ch;

    // Output register
    logic                         r_ovalid;
    logic [stp4_pkg::CH_BITS-1:0] r_o_ch;
    logic [POS_BITS-1:0]          r_o_pos;
    logic [PERIOD_BITS-1:0]       r_o_period;
    logic                         r_o_dir;
    logic                         r_o_mov;
    logic                         r_o_last;

    logic                          w_accept;
    logic                          w_slot;
    logic                          w_oload;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [NUM_BITS-1:0]           w_quo;
    logic [QW-1:0]                 w_quo_ext;
    logic [PERIOD_BITS-1:0]        w_sat;
    logic signed [DIFF_BITS-1:0]   w_diff;
    logic signed [DIFF_BITS-1:0]   w_neg;
    logic [POS_BITS-1:0]           w_dist;
    logic                          w_gt;
    logic                          w_lt;
    logic [stp4_pkg::BASE_BITS-1:0] w_base_eff;
    logic [POS_BITS-1:0]           w_tk_pos;
    logic                          w_tk_act;
    logic [PERIOD_BITS-1:0]        w_tk_per;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot      = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == stp4_pkg::ST_IDLE);

    // Signed distance of the current channel
    always_comb begin
        w_diff = signed'({r_tgt[r_ch][POS_BITS-1], r_tgt[r_ch]})
               - signed'({r_pos[r_ch][POS_BITS-1], r_pos[r_ch]});
        w_neg  = -w_diff;
        w_dist = w_diff[DIFF_BITS-1] ? w_neg[POS_BITS-1:0] : w_diff[POS_BITS-1:0];
        w_lt   = w_diff[DIFF_BITS-1];
        w_gt   = !w_diff[DIFF_BITS-1] && (w_diff != '0);
    end

    // Zero base period counts as one
    assign w_base_eff = (r_base == '0) ? stp4_pkg::BASE_BITS'(1) : r_base;

    // Quotient saturation to the period width
    always_comb begin
        w_quo_ext = QW'(w_quo);
        w_sat     = (w_quo_ext > QW'(PERIOD_MAX)) ? PERIOD_MAX : PERIOD_BITS'(w_quo_ext);
    end

    // Tick update of the current channel
    always_comb begin
        w_tk_pos = r_pos[r_ch];
        w_tk_act = r_act[r_ch];
        w_tk_per = r_period[r_ch];
        if (r_act[r_ch]) begin
            if (r_pos[r_ch] == r_aim[r_ch]) begin
                w_tk_act = 1'b0;
                w_tk_per = '0;
            end else if (r_sign[r_ch] == stp4_pkg::SIGN_PLUS) begin
                w_tk_pos = r_pos[r_ch] + 1'b1;
            end else if (r_sign[r_ch] == stp4_pkg::SIGN_MINUS) begin
                w_tk_pos = r_pos[r_ch] - 1'b1;
            end
        end
    end

    // Shared serial divider
    stp4_div #(
        .NUM_W (NUM_BITS),
        .DEN_W (POS_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_num),
        .i_divisor  (r_dist[r_ch]),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stp4_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and strobes
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_oload     = 1'b0;
        unique case (r_state)
            stp4_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.operation == stp4_pkg::OP_TICK) ?
                              stp4_pkg::ST_TICK : stp4_pkg::ST_DIST;
                end
            end
            stp4_pkg::ST_DIST: begin
                if (r_ch == LAST_CH) begin
                    n_state = stp4_pkg::ST_MUL;
                end
            end
            stp4_pkg::ST_MUL: begin
                n_state = stp4_pkg::ST_DIV_START;
            end
            stp4_pkg::ST_DIV_START: begin
                if (r_dist[r_ch] == '0) begin
                    n_state = stp4_pkg::ST_REPORT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = stp4_pkg::ST_DIV_WAIT;
                end
            end
            stp4_pkg::ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = stp4_pkg::ST_REPORT;
                end
            end
            stp4_pkg::ST_REPORT: begin
                if (w_slot) begin
                    w_oload = 1'b1;
                    n_state = (r_ch == LAST_CH) ? stp4_pkg::ST_IDLE : stp4_pkg::ST_DIV_START;
                end
            end
            stp4_pkg::ST_TICK: begin
                if (w_slot) begin
                    w_oload = 1'b1;
                    n_state = stp4_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stp4_pkg::ST_IDLE;
            end
        endcase
    end

    // Channel state, configuration and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= stp4_pkg::BASE_RESET;
            r_mask <= stp4_pkg::MASK_RESET;
            r_act  <= '0;
            for (int c = 0; c < stp4_pkg::NUM_CH; c++) begin
                r_pos[c]    <= '0;
                r_aim[c]    <= '0;
                r_sign[c]   <= stp4_pkg::SIGN_NONE;
                r_period[c] <= '0;
            end
        end else begin
            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    stp4_pkg::CFG_BASE_PERIOD: r_base <= i_cfg_data;
                    stp4_pkg::CFG_DIR_MASK:    r_mask <= i_cfg_data[stp4_pkg::MASK_BITS-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                stp4_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_tgt[0] <= i_in.target_zero;
                        r_tgt[1] <= i_in.target_one;
                        r_tgt[2] <= i_in.target_two;
                        r_tgt[3] <= i_in.target_three;
                        r_maxd   <= '0;
                        r_ch     <= (i_in.operation == stp4_pkg::OP_TICK) ?
                                    i_in.tick_channel : '0;
                    end
                end
                stp4_pkg::ST_DIST: begin
                    // one channel per cycle: aim, sign, flag, distance, running max
                    r_aim[r_ch]  <= r_tgt[r_ch];
                    r_dist[r_ch] <= w_dist;
                    if (w_gt) begin
                        r_sign[r_ch] <= stp4_pkg::SIGN_PLUS;
                        r_act[r_ch]  <= 1'b1;
                    end else if (w_lt) begin
                        r_sign[r_ch] <= stp4_pkg::SIGN_MINUS;
                        r_act[r_ch]  <= 1'b1;
                    end else begin
                        r_act[r_ch]  <= 1'b0;
                    end
                    if (w_dist > r_maxd) begin
                        r_maxd <= w_dist;
                    end
                    r_ch <= r_ch + 1'b1;
                end
                stp4_pkg::ST_MUL: begin
                    r_num <= NUM_BITS'(w_base_eff) * NUM_BITS'(r_maxd);
                end
                stp4_pkg::ST_DIV_START: begin
                    if (r_dist[r_ch] == '0) begin
                        r_period[r_ch] <= '0;
                    end
                end
                stp4_pkg::ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_period[r_ch] <= w_sat;
                    end
                end
                stp4_pkg::ST_REPORT: begin
                    if (w_slot) begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                stp4_pkg::ST_TICK: begin
                    if (w_slot) begin
                        r_pos[r_ch]    <= w_tk_pos;
                        r_act[r_ch]    <= w_tk_act;
                        r_period[r_ch] <= w_tk_per;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output payload: tick beats carry the updated channel state
    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_o_ch  <= r_ch;
            r_o_dir <= (r_sign[r_ch] == stp4_pkg::SIGN_PLUS) ^ r_mask[r_ch];
            if (r_state == stp4_pkg::ST_TICK) begin
                r_o_pos    <= w_tk_pos;
                r_o_period <= w_tk_per;
                r_o_mov    <= w_tk_act;
                r_o_last   <= 1'b1;
            end else begin
                r_o_pos    <= r_pos[r_ch];
                r_o_period <= r_period[r_ch];
                r_o_mov    <= r_act[r_ch];
                r_o_last   <= (r_ch == LAST_CH);
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.channel     = r_o_ch;
    assign o_out.position    = r_o_pos;
    assign o_out.step_period = r_o_period;
    assign o_out.dir_pin     = r_o_dir;
    assign o_out.moving      = r_o_mov;
    assign o_out.last        = r_o_last;

    // Checks
    `STP4_ASSERT_NOW(a_idle_no_period, i_clk, i_rst_n, r_ovalid && !r_o_mov, r_o_period == '0)
    `STP4_ASSERT_NOW(a_not_last_low_ch, i_clk, i_rst_n, r_ovalid && !r_o_last, r_o_ch != LAST_CH)
    `STP4_ASSERT_NOW(a_div_done_wait, i_clk, i_rst_n, w_div_done, r_state == stp4_pkg::ST_DIV_WAIT)
    `STP4_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != stp4_pkg::ST_IDLE)

endmodule
